// ===== rtl/dps_pkg.sv =====
// dps_pkg: shared types and constants of the priority ready queue
`timescale 1ns / 1ps
`default_nettype none

package dps_pkg;

    // default queue size and stored entry width
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int ENTRY_W         = 32;

    // command codes
    localparam logic CMD_ADD      = 1'b0;
    localparam logic CMD_DISPATCH = 1'b1;

    // result status codes
    localparam logic [2:0] ST_ADDED    = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_BAD_TIME = 3'd2;
    localparam logic [2:0] ST_REQUEUED = 3'd3;
    localparam logic [2:0] ST_FINISHED = 3'd4;
    localparam logic [2:0] ST_EMPTY    = 3'd5;

    // lowest priority, a requeued process saturates here
    localparam logic signed [7:0] PRIO_MIN = 8'sh80;

    // input command transfer
    typedef struct packed {
        logic              command;
        logic [7:0]        process_id;
        logic signed [7:0] priority_req;
        logic [7:0]        needed_time;
    } t_cmd;

    // result transfer
    typedef struct packed {
        logic [2:0]        status;
        logic [7:0]        run_id;
        logic signed [7:0] run_priority;
        logic [7:0]        run_elapsed;
        logic [4:0]        queue_count;
    } t_res;

    // one stored queue entry
    typedef struct packed {
        logic [7:0]        elapsed;
        logic [7:0]        needed;
        logic signed [7:0] prio;
        logic [7:0]        id;
    } t_entry;

endpackage

`default_nettype wire

// ===== rtl/dps_ram.sv =====
// dps_ram: generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
`default_nettype none

module dps_ram
    import dps_pkg::*;
#(
    parameter int WIDTH = ENTRY_W,
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/dynamic_priority_scheduler_core.sv =====
// dynamic_priority_scheduler_core: priority ready queue kept sorted in a circular ram
//
//  channel  direction  handshake                     payload
//  command  in         i_in_valid / o_in_ready       i_in_data  (t_cmd)
//  result   out        o_out_valid / i_out_ready     o_out_data (t_res)
//
//  one command at a time; the queue lives in a circular buffer in one ram.
//  add: a walk from the tail, with one ram read per entry walked.
//  dispatch: head read plus, unless the process finishes, a reinsertion walk.
//  rejected adds and dispatch on empty queue go straight to the response state.
//  reset (synchronous, active low) empties the queue; ram contents are not cleared.
//  a stalled result waits in the output register while the next command is taken.
`timescale 1ns / 1ps
`default_nettype none

module dynamic_priority_scheduler_core
    import dps_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_cmd i_in_data,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    output t_res      o_out_data
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_HEAD  = 6'b000010,
        S_INS   = 6'b000100,
        S_SCAN  = 6'b001000,
        S_PLACE = 6'b010000,
        S_RESP  = 6'b100000
    } t_state;

    t_state          r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic [AW-1:0]   r_head,  n_head;
    logic [AW-1:0]   r_idx,   n_idx;
    t_entry          r_ent,   n_ent;
    t_res            r_res,   n_res;
    logic            r_out_valid, n_out_valid;
    t_res            r_out,   n_out;

    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    logic [AW-1:0]   ram_raddr;
    t_entry          ram_wdata;
    t_entry          ram_rdata;

    logic            in_xfer;
    logic [AW-1:0]   idx_inc;
    logic [AW-1:0]   idx_dec;
    logic [AW-1:0]   cnt_dec;
    logic [AW-1:0]   head_inc;
    logic [7:0]      elapsed_inc;

    // logical queue position to ram address
    function automatic logic [AW-1:0] f_phys(input logic [AW-1:0] head,
                                              input logic [AW-1:0] pos);
        logic [AW:0] sum;
        sum = {1'b0, head} + {1'b0, pos};
        if (sum >= (AW+1)'(QUEUE_DEPTH)) begin
            sum = sum - (AW+1)'(QUEUE_DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    dps_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // handshake and index arithmetic
    assign o_in_ready  = (r_state == S_IDLE);
    assign in_xfer     = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign idx_inc     = r_idx + AW'(1);
    assign idx_dec     = r_idx - AW'(1);
    assign cnt_dec     = AW'(r_count - CW'(1));
    assign head_inc    = (r_head == AW'(QUEUE_DEPTH - 1)) ? '0 : r_head + AW'(1);
    assign elapsed_inc = ram_rdata.elapsed + 8'd1;

    // command sequencer
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_head      = r_head;
        n_idx       = r_idx;
        n_ent       = r_ent;
        n_res       = r_res;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        ram_we      = 1'b0;
        ram_waddr   = f_phys(r_head, idx_inc);
        ram_wdata   = r_ent;
        ram_raddr   = r_head;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_res       = '0;
                    n_ent.elapsed = 8'd0;
                    n_ent.needed  = i_in_data.needed_time;
                    n_ent.prio    = i_in_data.priority_req;
                    n_ent.id      = i_in_data.process_id;
                    if (i_in_data.command == CMD_ADD) begin
                        if (i_in_data.needed_time == 8'd0) begin
                            n_res.status = ST_BAD_TIME;
                            n_state      = S_RESP;
                        end else if (r_count == CW'(QUEUE_DEPTH)) begin
                            n_res.status = ST_FULL;
                            n_state      = S_RESP;
                        end else begin
                            n_res.status = ST_ADDED;
                            n_state      = S_INS;
                        end
                    end else if (r_count == '0) begin
                        n_res.status = ST_EMPTY;
                        n_state      = S_RESP;
                    end else begin
                        ram_raddr = r_head;
                        n_state   = S_HEAD;
                    end
                end
            end

            // head entry arrives: charge one slice and pop it
            S_HEAD: begin
                n_res.run_id       = ram_rdata.id;
                n_res.run_priority = ram_rdata.prio;
                n_res.run_elapsed  = elapsed_inc;
                n_count            = r_count - CW'(1);
                n_head             = head_inc;
                if (elapsed_inc == ram_rdata.needed) begin
                    n_res.status = ST_FINISHED;
                    n_state      = S_RESP;
                end else begin
                    n_res.status  = ST_REQUEUED;
                    n_ent.elapsed = elapsed_inc;
                    n_ent.needed  = ram_rdata.needed;
                    n_ent.id      = ram_rdata.id;
                    n_ent.prio    = (ram_rdata.prio == PRIO_MIN) ? PRIO_MIN
                                                                 : ram_rdata.prio - 8'sd1;
                    n_state       = S_INS;
                end
            end

            // start the walk from the tail, or write an empty queue's only entry at the front
            S_INS: begin
                if (r_count == '0) begin
                    ram_we    = 1'b1;
                    ram_waddr = f_phys(r_head, '0);
                    n_count   = r_count + CW'(1);
                    n_state   = S_RESP;
                end else begin
                    ram_raddr = f_phys(r_head, cnt_dec);
                    n_idx     = cnt_dec;
                    n_state   = S_SCAN;
                end
            end

            // shift lower-priority entries up by one until the slot is found
            S_SCAN: begin
                ram_we    = 1'b1;
                ram_waddr = f_phys(r_head, idx_inc);
                if (r_ent.prio > ram_rdata.prio) begin
                    ram_wdata = ram_rdata;
                    if (r_idx == '0) begin
                        n_state = S_PLACE;
                    end else begin
                        ram_raddr = f_phys(r_head, idx_dec);
                        n_idx     = idx_dec;
                    end
                end else begin
                    ram_wdata = r_ent;
                    n_count   = r_count + CW'(1);
                    n_state   = S_RESP;
                end
            end

            // new entry goes to the front
            S_PLACE: begin
                ram_we    = 1'b1;
                ram_waddr = f_phys(r_head, '0);
                n_count   = r_count + CW'(1);
                n_state   = S_RESP;
            end

            // hand the result to the output register
            S_RESP: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out             = r_res;
                    n_out.queue_count = 5'(r_count);
                    n_out_valid       = 1'b1;
                    n_state           = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_head      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_head      <= n_head;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_ent <= n_ent;
        r_res <= n_res;
        r_out <= n_out;
    end

    // occupancy never exceeds the ram
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    // ram is written only while inserting
    a_write_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == S_INS || r_state == S_SCAN || r_state == S_PLACE))
        else $error("ram write outside insertion");

    // zero time add is rejected straight away
    a_bad_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && i_in_data.command == CMD_ADD && i_in_data.needed_time == 8'd0)
        |=> (r_state == S_RESP && r_res.status == ST_BAD_TIME))
        else $error("zero time add not rejected");

    // dispatch on an empty queue reports empty
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && i_in_data.command == CMD_DISPATCH && r_count == '0)
        |=> (r_state == S_RESP && r_res.status == ST_EMPTY))
        else $error("empty dispatch not reported");

    // occupancy moves by at most one per cycle
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == $past(r_count) || r_count == $past(r_count) + CW'(1)
         || r_count == $past(r_count) - CW'(1)))
        else $error("queue count jumped");

endmodule

`default_nettype wire

// ===== tb/dynamic_priority_scheduler_core_test.sv =====
// self-checking testbench of the priority ready queue scheduler core
`timescale 1ns / 1ps

module dynamic_priority_scheduler_core_test;
    import dps_pkg::*;

    localparam int DEPTH        = QUEUE_DEPTH_DEF;
    localparam int IDLE_PCT     = 6;
    localparam int SETTLE_CYC   = 40;
    localparam int LIMIT_CYCLES = 400000;
    localparam int MAX_PRINTS   = 30;

    logic i_clk;
    logic i_rst_n     = 1'b0;
    logic i_in_valid  = 1'b0;
    logic o_in_ready;
    t_cmd i_in_data   = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b1;
    t_res o_out_data;

    dynamic_priority_scheduler_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // shadow copy of the ready queue, head at index 0
    t_entry      ready_q [DEPTH];
    int unsigned ready_n = 0;

    t_res        pending_results [$];
    int unsigned error_count  = 0;
    int unsigned cmd_count    = 0;
    int unsigned result_count = 0;
    int unsigned status_tally [6];
    int unsigned cycle_count  = 0;
    bit          quiet = 1'b0;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // insert by priority, behind every entry of equal or higher priority
    function automatic void insert_entry(t_entry e);
        int pos;
        pos = ready_n;
        for (int i = 0; i < ready_n; i++) begin
            if ($signed(e.prio) > $signed(ready_q[i].prio)) begin
                pos = i;
                break;
            end
        end
        for (int k = ready_n; k > pos; k--)
            ready_q[k] = ready_q[k-1];
        ready_q[pos] = e;
        ready_n++;
    endfunction

    // expected result of one command, updates the shadow queue
    function automatic t_res predict_schedule(t_cmd c);
        t_res   r;
        t_entry h;
        r = '0;
        if (c.command == CMD_ADD) begin
            if (c.needed_time == 8'd0) begin
                r.status = ST_BAD_TIME;
            end else if (ready_n >= DEPTH) begin
                r.status = ST_FULL;
            end else begin
                h.id      = c.process_id;
                h.prio    = c.priority_req;
                h.needed  = c.needed_time;
                h.elapsed = 8'd0;
                insert_entry(h);
                r.status = ST_ADDED;
            end
        end else if (ready_n == 0) begin
            r.status = ST_EMPTY;
        end else begin
            h = ready_q[0];
            for (int k = 0; k < ready_n - 1; k++)
                ready_q[k] = ready_q[k+1];
            ready_n--;
            h.elapsed      = h.elapsed + 8'd1;
            r.run_id       = h.id;
            r.run_priority = h.prio;
            r.run_elapsed  = h.elapsed;
            if (h.elapsed == h.needed) begin
                r.status = ST_FINISHED;
            end else begin
                // priority decays by one but never below the minimum
                if (h.prio != PRIO_MIN)
                    h.prio = h.prio - 8'sd1;
                insert_entry(h);
                r.status = ST_REQUEUED;
            end
        end
        r.queue_count = 5'(ready_n);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (error_count < MAX_PRINTS)
            $display("mismatch at cycle %0d: %s got %0h want %0h",
                     cycle_count, what, got, want);
        error_count++;
    endtask

    // result receiver stalls at random unless quiet
    always @(posedge i_clk) begin
        i_out_ready <= !(!quiet && $urandom_range(99) < IDLE_PCT);
    end

    // predict on each command transfer, check each result transfer
    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                want = predict_schedule(i_in_data);
                pending_results.push_back(want);
                status_tally[want.status]++;
                cmd_count++;
            end
            if (o_out_valid && i_out_ready) begin
                result_count++;
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected result", o_out_data, '0);
                end else begin
                    want = pending_results.pop_front();
                    if (o_out_data.status !== want.status)
                        report_mismatch("status", 32'(o_out_data.status),
                                        32'(want.status));
                    if (o_out_data.run_id !== want.run_id)
                        report_mismatch("run_id", 32'(o_out_data.run_id),
                                        32'(want.run_id));
                    if (o_out_data.run_priority !== want.run_priority)
                        report_mismatch("run_priority", 32'(o_out_data.run_priority),
                                        32'(want.run_priority));
                    if (o_out_data.run_elapsed !== want.run_elapsed)
                        report_mismatch("run_elapsed", 32'(o_out_data.run_elapsed),
                                        32'(want.run_elapsed));
                    if (o_out_data.queue_count !== want.queue_count)
                        report_mismatch("queue_count", 32'(o_out_data.queue_count),
                                        32'(want.queue_count));
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("FAILURE");
            $finish;
        end
    end

    // one command transfer, with an occasional gap in front of it
    task automatic send_cmd(input t_cmd c);
        while (!quiet && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= c;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic send_add(input logic [7:0] id, input logic signed [7:0] prio,
                            input logic [7:0] need);
        t_cmd c;
        c.command      = CMD_ADD;
        c.process_id   = id;
        c.priority_req = prio;
        c.needed_time  = need;
        send_cmd(c);
    endtask

    task automatic send_dispatch();
        t_cmd c;
        c.process_id   = 8'($urandom);
        c.priority_req = 8'($urandom);
        c.needed_time  = 8'($urandom);
        c.command      = CMD_DISPATCH;
        send_cmd(c);
    endtask

    // stop sending and wait until every result has come back
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // process at minimum priority stays there when requeued
    task automatic test_priority_floor();
        send_add(8'h00, PRIO_MIN, 8'd2);
        send_dispatch();
        send_dispatch();
    endtask

    // dispatch on empty queue, zero needed time
    task automatic test_empty_and_bad_time();
        send_dispatch();
        send_add(8'h5a, 8'sd3, 8'd0);
    endtask

    // ordering by priority, arrival order among equals, field extremes
    task automatic test_ordering();
        send_add(8'hff, 8'sd127, 8'd1);
        send_add(8'h11, 8'sd0, 8'd1);
        send_add(8'h22, 8'sd0, 8'd3);
        send_add(8'h80, -8'sd1, 8'd255);
        send_dispatch();
        send_dispatch();
        send_add(8'h33, 8'sd0, 8'd2);
    endtask

    // fill the queue, then one add too many and a zero-time add on a full queue
    task automatic test_full_queue();
        int fill;
        wait_drained();
        fill = DEPTH - ready_n;
        for (int i = 0; i < fill; i++)
            send_add(8'($urandom), 8'($urandom), 8'($urandom_range(255, 1)));
        send_add(8'($urandom), 8'($urandom), 8'($urandom_range(255, 1)));
        send_add(8'($urandom), 8'($urandom), 8'd0);
    endtask

    // random mix of adds and dispatches, add_pct sets how full the queue runs
    task automatic test_random_traffic(input int count, input int add_pct,
                                       input bit no_idle);
        int          roll;
        logic [7:0]  need;
        quiet = no_idle;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(99) < add_pct) begin
                roll = $urandom_range(99);
                if (roll < 5)
                    need = 8'd0;
                else if (roll < 85)
                    need = 8'($urandom_range(6, 1));
                else
                    need = 8'($urandom_range(255, 1));
                send_add(8'($urandom), 8'($urandom), need);
            end else begin
                send_dispatch();
            end
        end
        wait_drained();
        quiet = 1'b0;
    endtask

    // main sequence
    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_priority_floor();
        test_empty_and_bad_time();
        test_ordering();
        test_full_queue();

        test_random_traffic(350, 55, 1'b0);
        test_random_traffic(300, 75, 1'b0);
        test_random_traffic(350, 30, 1'b0);
        test_random_traffic(300, 50, 1'b1);

        repeat (SETTLE_CYC) @(posedge i_clk);

        $display("%0d commands sent, %0d results checked", cmd_count, result_count);
        $display("added %0d, full %0d, bad time %0d, requeued %0d, finished %0d, empty %0d",
                 status_tally[ST_ADDED], status_tally[ST_FULL],
                 status_tally[ST_BAD_TIME], status_tally[ST_REQUEUED],
                 status_tally[ST_FINISHED], status_tally[ST_EMPTY]);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/dps_pkg.sv
rtl/dps_ram.sv
rtl/dynamic_priority_scheduler_core.sv
tb/dynamic_priority_scheduler_core_test.sv
